// ===== hdl/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared widths, codes and record types of the circuit breaker table.
// ----------------------------------------------------------------------------
package cbt_pkg;

  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned NOW_W    = 48;
  localparam int unsigned GEN_W    = 30;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned STREAK_W = 5;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned STATE_W  = 2;

  localparam int unsigned BREAKER_COUNT_DEF = 64;
  localparam int unsigned TABLE_MAX         = 1 << INDEX_W;
  localparam int unsigned STREAK_MAX        = 16;
  localparam int unsigned PCT_SCALE         = 100;
  localparam int unsigned PROD_W            = CNT_W + PCT_W;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;

  // breaker modes, also used for permit and grant state
  localparam logic [STATE_W-1:0] MODE_CLOSED = 2'd0;
  localparam logic [STATE_W-1:0] MODE_OPEN   = 2'd1;
  localparam logic [STATE_W-1:0] MODE_HALF   = 2'd2;

  localparam logic CMD_ADMIT   = 1'b0;
  localparam logic CMD_OUTCOME = 1'b1;

  typedef enum logic [2:0] {
    REG_PROBE_LIMIT,
    REG_WINDOW_LENGTH,
    REG_MINIMUM_CALLS,
    REG_FAILURE_PERCENT,
    REG_BASE_OPEN,
    REG_MAX_OPEN,
    REG_BACKOFF
  } reg_idx_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_PREP,
    FSM_COMMIT
  } fsm_e;

  typedef struct packed {
    logic [CNT_W-1:0] half_open_probe_limit;
    logic [CNT_W-1:0] window_length;
    logic [CNT_W-1:0] minimum_calls;
    logic [PCT_W-1:0] failure_percent;
    logic [MS_W-1:0]  base_open_ms;
    logic [MS_W-1:0]  max_open_ms;
    logic [MS_W-1:0]  overload_backoff_ms;
  } cfg_t;

  typedef struct packed {
    logic               command;
    logic [INDEX_W-1:0] breaker_index;
    logic [NOW_W-1:0]   now_ms;
    logic [STATE_W-1:0] permit_state;
    logic [GEN_W-1:0]   permit_generation;
    logic               call_ok;
    logic               local_failure;
    logic               overload;
    logic               transport_failure;
  } item_t;

  typedef struct packed {
    logic [STATE_W-1:0]  mode;
    logic [GEN_W-1:0]    generation_count;
    logic [CNT_W-1:0]    probes_in_flight;
    logic [CNT_W-1:0]    probe_successes;
    logic [CNT_W-1:0]    window_calls;
    logic [CNT_W-1:0]    window_failures;
    logic [NOW_W-1:0]    reopen_time;
    logic [NOW_W-1:0]    overload_end_time;
    logic [STREAK_W-1:0] open_streak;
  } entry_t;

  typedef struct packed {
    logic               granted;
    logic [STATE_W-1:0] grant_state;
    logic [GEN_W-1:0]   grant_generation;
    logic [STATE_W-1:0] breaker_state;
    logic               tripped;
  } result_t;

endpackage

// ===== hdl/cbt_if.sv =====
// ----------------------------------------------------------------------------
// cbt_if
// Valid/ready channels of the circuit breaker table: request and result.
// ----------------------------------------------------------------------------
interface cbt_item_if;
  import cbt_pkg::*;

  logic               valid;
  logic               ready;
  logic               command;
  logic [INDEX_W-1:0] breaker_index;
  logic [NOW_W-1:0]   now_ms;
  logic [STATE_W-1:0] permit_state;
  logic [GEN_W-1:0]   permit_generation;
  logic               call_ok;
  logic               local_failure;
  logic               overload;
  logic               transport_failure;

  modport source (
    output valid, command, breaker_index, now_ms, permit_state, permit_generation,
           call_ok, local_failure, overload, transport_failure,
    input  ready
  );

  modport sink (
    input  valid, command, breaker_index, now_ms, permit_state, permit_generation,
           call_ok, local_failure, overload, transport_failure,
    output ready
  );
endinterface

interface cbt_result_if;
  import cbt_pkg::*;

  logic               valid;
  logic               ready;
  logic               granted;
  logic [STATE_W-1:0] grant_state;
  logic [GEN_W-1:0]   grant_generation;
  logic [STATE_W-1:0] breaker_state;
  logic               tripped;

  modport source (
    output valid, granted, grant_state, grant_generation, breaker_state, tripped,
    input  ready
  );

  modport sink (
    input  valid, granted, grant_state, grant_generation, breaker_state, tripped,
    output ready
  );
endinterface

// ===== hdl/cbt_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cbt_cfg_regs
// APB register file holding the breaker thresholds and intervals.
// ----------------------------------------------------------------------------
module cbt_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cbt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cbt_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output cbt_pkg::cfg_t                  cfg_o
);
  import cbt_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e reg_sel;
  logic     wr_en;

  assign reg_sel = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_PROBE_LIMIT:     cfg_d.half_open_probe_limit = pwdata[CNT_W-1:0];
        REG_WINDOW_LENGTH:   cfg_d.window_length         = pwdata[CNT_W-1:0];
        REG_MINIMUM_CALLS:   cfg_d.minimum_calls         = pwdata[CNT_W-1:0];
        REG_FAILURE_PERCENT: cfg_d.failure_percent       = pwdata[PCT_W-1:0];
        REG_BASE_OPEN:       cfg_d.base_open_ms          = pwdata[MS_W-1:0];
        REG_MAX_OPEN:        cfg_d.max_open_ms           = pwdata[MS_W-1:0];
        REG_BACKOFF:         cfg_d.overload_backoff_ms   = pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_open_probe_limit <= CNT_W'(3);
      cfg_q.window_length         <= CNT_W'(100);
      cfg_q.minimum_calls         <= CNT_W'(20);
      cfg_q.failure_percent       <= PCT_W'(50);
      cfg_q.base_open_ms          <= MS_W'(1000);
      cfg_q.max_open_ms           <= MS_W'(60000);
      cfg_q.overload_backoff_ms   <= MS_W'(100);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_PROBE_LIMIT:     prdata = APB_DATA_W'(cfg_q.half_open_probe_limit);
      REG_WINDOW_LENGTH:   prdata = APB_DATA_W'(cfg_q.window_length);
      REG_MINIMUM_CALLS:   prdata = APB_DATA_W'(cfg_q.minimum_calls);
      REG_FAILURE_PERCENT: prdata = APB_DATA_W'(cfg_q.failure_percent);
      REG_BASE_OPEN:       prdata = APB_DATA_W'(cfg_q.base_open_ms);
      REG_MAX_OPEN:        prdata = APB_DATA_W'(cfg_q.max_open_ms);
      REG_BACKOFF:         prdata = APB_DATA_W'(cfg_q.overload_backoff_ms);
      default:             prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/cbt_entry_mem.sv =====
// ----------------------------------------------------------------------------
// cbt_entry_mem
// Breaker record memory, registered synchronous read, with per-entry valid
// bits so that unwritten entries read as the all-zero reset record.
// ----------------------------------------------------------------------------
module cbt_entry_mem #(
  parameter int unsigned DEPTH  = cbt_pkg::TABLE_MAX,
  parameter int unsigned ADDR_W = cbt_pkg::INDEX_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [ADDR_W-1:0]   rd_addr_i,
  output cbt_pkg::entry_t     rd_data_o,
  input  logic                wr_en_i,
  input  logic [ADDR_W-1:0]   wr_addr_i,
  input  cbt_pkg::entry_t     wr_data_i
);
  import cbt_pkg::*;

  entry_t           mem_q [DEPTH];
  entry_t           rd_q;
  logic [DEPTH-1:0] valid_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

// ===== hdl/cbt_update.sv =====
// ----------------------------------------------------------------------------
// cbt_update
// Two-stage breaker update: a prep stage of counts, interval and time
// compares, then the decision that yields the new record and the result.
// ----------------------------------------------------------------------------
module cbt_update #(
  parameter int unsigned BREAKER_COUNT = cbt_pkg::BREAKER_COUNT_DEF
) (
  input  logic            clk_i,
  input  logic            prep_en_i,
  input  cbt_pkg::item_t  item_i,
  input  cbt_pkg::entry_t entry_i,
  input  cbt_pkg::cfg_t   cfg_i,
  output cbt_pkg::entry_t entry_o,
  output cbt_pkg::result_t result_o
);
  import cbt_pkg::*;

  localparam int unsigned WIDE_W = MS_W + STREAK_MAX;

  typedef struct packed {
    logic                in_range;
    logic                ovl_block;
    logic                reopen_due;
    logic                probes_lt;
    logic                same_gen;
    logic                close_ok;
    logic [GEN_W-1:0]    gen_inc;
    logic [CNT_W-1:0]    cnt;
    logic [CNT_W-1:0]    fl;
    logic [CNT_W-1:0]    succ;
    logic [CNT_W-1:0]    probes_dec;
    logic [MS_W-1:0]     interval;
    logic [STREAK_W-1:0] streak_next;
    logic [NOW_W-1:0]    ovl_time;
  } prep_t;

  function automatic logic [NOW_W-1:0] sat_add(input logic [NOW_W-1:0] a,
                                               input logic [MS_W-1:0] b);
    logic [NOW_W:0] s;
    s = {1'b0, a} + (NOW_W+1)'(b);
    return s[NOW_W] ? '1 : s[NOW_W-1:0];
  endfunction

  prep_t p_d;
  prep_t p_q;

  logic [CNT_W-1:0]    cnt0;
  logic [CNT_W-1:0]    fl0;
  logic [CNT_W:0]      cnt_sum;
  logic [CNT_W:0]      fl_sum;
  logic [CNT_W-1:0]    cnt_sat;
  logic [CNT_W:0]      succ_sum;
  logic [STREAK_W-1:0] shamt;
  logic [WIDE_W-1:0]   wide_iv;

  // ---------------- prep stage ----------------
  always_comb begin
    p_d.in_range   = 32'(item_i.breaker_index) < 32'(BREAKER_COUNT);
    p_d.ovl_block  = item_i.now_ms < entry_i.overload_end_time;
    p_d.reopen_due = item_i.now_ms >= entry_i.reopen_time;
    p_d.probes_lt  = entry_i.probes_in_flight < cfg_i.half_open_probe_limit;
    p_d.same_gen   = entry_i.generation_count == item_i.permit_generation;
    p_d.gen_inc    = entry_i.generation_count + 1'b1;

    // window restarts once the count reaches the window length
    if (entry_i.window_calls >= cfg_i.window_length) begin
      cnt0 = '0;
      fl0  = '0;
    end else begin
      cnt0 = entry_i.window_calls;
      fl0  = entry_i.window_failures;
    end
    cnt_sum = {1'b0, cnt0} + 1'b1;
    fl_sum  = {1'b0, fl0} + (CNT_W+1)'(item_i.transport_failure);
    cnt_sat = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
    p_d.cnt = cnt_sat;
    p_d.fl  = (fl_sum > {1'b0, cnt_sat}) ? cnt_sat : fl_sum[CNT_W-1:0];

    succ_sum  = {1'b0, entry_i.probe_successes} + (CNT_W+1)'(item_i.call_ok);
    p_d.succ  = succ_sum[CNT_W] ? '1 : succ_sum[CNT_W-1:0];
    p_d.close_ok = (entry_i.probes_in_flight == CNT_W'(1)) &&
                   (p_d.succ >= cfg_i.half_open_probe_limit);
    p_d.probes_dec = (entry_i.probes_in_flight == '0) ? '0 :
                     entry_i.probes_in_flight - 1'b1;

    // doubling open interval, clamped at the ceiling
    shamt = (entry_i.open_streak > STREAK_W'(STREAK_MAX)) ? STREAK_W'(STREAK_MAX) :
            entry_i.open_streak;
    wide_iv = WIDE_W'(cfg_i.base_open_ms) << shamt;
    p_d.interval = (wide_iv > WIDE_W'(cfg_i.max_open_ms)) ? cfg_i.max_open_ms :
                   wide_iv[MS_W-1:0];
    p_d.streak_next = (entry_i.open_streak < STREAK_W'(STREAK_MAX)) ?
                      entry_i.open_streak + 1'b1 : entry_i.open_streak;

    p_d.ovl_time = sat_add(item_i.now_ms, cfg_i.overload_backoff_ms);
  end

  always_ff @(posedge clk_i) begin
    if (prep_en_i) begin
      p_q <= p_d;
    end
  end

  // ---------------- decision stage ----------------
  logic [PROD_W-1:0] fail_prod;
  logic [PROD_W-1:0] call_prod;
  logic [NOW_W-1:0]  trip_time;
  logic              do_trip;
  entry_t            e_n;
  result_t           res;

  assign fail_prod = PROD_W'(p_q.fl) * PROD_W'(PCT_SCALE);
  assign call_prod = PROD_W'(p_q.cnt) * PROD_W'(cfg_i.failure_percent);
  assign trip_time = sat_add(item_i.now_ms, p_q.interval);

  always_comb begin
    e_n     = entry_i;
    res     = '0;
    do_trip = 1'b0;
    if (p_q.in_range) begin
      if (item_i.command == CMD_ADMIT) begin
        if (!p_q.ovl_block) begin
          case (entry_i.mode)
            MODE_OPEN: begin
              if (p_q.reopen_due) begin
                e_n.generation_count = p_q.gen_inc;
                e_n.mode             = MODE_HALF;
                e_n.probes_in_flight = CNT_W'(1);
                e_n.probe_successes  = '0;
                res.granted          = 1'b1;
                res.grant_state      = MODE_HALF;
                res.grant_generation = p_q.gen_inc;
              end
            end
            MODE_HALF: begin
              if (p_q.probes_lt) begin
                e_n.probes_in_flight = entry_i.probes_in_flight + 1'b1;
                res.granted          = 1'b1;
                res.grant_state      = MODE_HALF;
                res.grant_generation = entry_i.generation_count;
              end
            end
            default: begin
              res.granted          = 1'b1;
              res.grant_state      = MODE_CLOSED;
              res.grant_generation = entry_i.generation_count;
            end
          endcase
        end
      end else begin
        if (item_i.overload) begin
          e_n.overload_end_time = p_q.ovl_time;
        end
        if (item_i.permit_state == MODE_HALF) begin
          if (entry_i.mode == MODE_HALF && p_q.same_gen) begin
            if (item_i.transport_failure) begin
              do_trip = 1'b1;
            end else if (p_q.close_ok) begin
              e_n.mode             = MODE_CLOSED;
              e_n.generation_count = p_q.gen_inc;
              e_n.probes_in_flight = '0;
              e_n.probe_successes  = '0;
              e_n.window_calls     = '0;
              e_n.window_failures  = '0;
              e_n.open_streak      = '0;
            end else begin
              e_n.probes_in_flight = p_q.probes_dec;
              e_n.probe_successes  = p_q.succ;
            end
          end
        end else if (!item_i.local_failure && !item_i.overload &&
                     item_i.permit_state == MODE_CLOSED &&
                     entry_i.mode == MODE_CLOSED && p_q.same_gen) begin
          e_n.window_calls    = p_q.cnt;
          e_n.window_failures = p_q.fl;
          if (p_q.cnt >= cfg_i.minimum_calls && fail_prod >= call_prod) begin
            do_trip = 1'b1;
          end
        end
      end
      if (do_trip) begin
        e_n.open_streak      = p_q.streak_next;
        e_n.reopen_time      = trip_time;
        e_n.window_calls     = '0;
        e_n.window_failures  = '0;
        e_n.generation_count = p_q.gen_inc;
        e_n.probes_in_flight = '0;
        e_n.probe_successes  = '0;
        e_n.mode             = MODE_OPEN;
      end
      res.breaker_state = e_n.mode;
      res.tripped       = do_trip;
    end
  end

  assign entry_o  = e_n;
  assign result_o = res;

endmodule

// ===== hdl/circuit_breaker_table_top.sv =====
// ----------------------------------------------------------------------------
// circuit_breaker_table_top
// Table of closed / open / half-open circuit breakers with APB configuration.
// ----------------------------------------------------------------------------
// Each request beat names one breaker and either asks for admission or reports
// a call outcome; exactly one result beat comes back per request, in order.
// The record of an item is read from the table memory at the accept edge,
// counts, open interval and time compares are prepared in the prep state,
// and the decision and write back of the record happen in the commit state;
// the next request is taken once the control is back in the idle state. The
// control state machine serialises the read-modify-write, so one item is in
// work at a time. Entries come out of reset closed with all counts zero via
// per-entry valid bits, so no clearing pass is needed after reset. The result
// register lets a new request be taken in the same cycle its result is taken.
// Configuration may be written only while no request is in work.
// ----------------------------------------------------------------------------
module circuit_breaker_table_top #(
  parameter int unsigned BREAKER_COUNT = cbt_pkg::BREAKER_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cbt_item_if.sink                       item_i,
  cbt_result_if.source                   result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cbt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cbt_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import cbt_pkg::*;

  localparam int unsigned DEPTH  = (BREAKER_COUNT < TABLE_MAX) ? BREAKER_COUNT : TABLE_MAX;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fsm_e    state_q;
  fsm_e    state_d;
  item_t   item_q;
  item_t   item_in;
  entry_t  entry_rd;
  entry_t  entry_wr;
  result_t res_new;
  result_t res_q;
  logic    res_valid_q;
  logic    res_valid_d;
  logic    accept;
  logic    in_ready;
  logic    prep_en;
  logic    commit;
  cfg_t    cfg;

  assign item_in.command           = item_i.command;
  assign item_in.breaker_index     = item_i.breaker_index;
  assign item_in.now_ms            = item_i.now_ms;
  assign item_in.permit_state      = item_i.permit_state;
  assign item_in.permit_generation = item_i.permit_generation;
  assign item_in.call_ok           = item_i.call_ok;
  assign item_in.local_failure     = item_i.local_failure;
  assign item_in.overload          = item_i.overload;
  assign item_in.transport_failure = item_i.transport_failure;

  // ---------------- control ----------------
  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    prep_en  = 1'b0;
    commit   = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        in_ready = !res_valid_q || result_o.ready;
        if (item_i.valid && in_ready) begin
          state_d = FSM_PREP;
        end
      end
      FSM_PREP: begin
        prep_en = 1'b1;
        state_d = FSM_COMMIT;
      end
      FSM_COMMIT: begin
        commit  = 1'b1;
        state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  assign accept       = item_i.valid && in_ready;
  assign item_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_in;
    end
  end

  // ---------------- datapath ----------------
  cbt_entry_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (item_i.breaker_index[ADDR_W-1:0]),
    .rd_data_o (entry_rd),
    .wr_en_i   (commit && (32'(item_q.breaker_index) < 32'(BREAKER_COUNT))),
    .wr_addr_i (item_q.breaker_index[ADDR_W-1:0]),
    .wr_data_i (entry_wr)
  );

  cbt_update #(
    .BREAKER_COUNT (BREAKER_COUNT)
  ) u_update (
    .clk_i     (clk_i),
    .prep_en_i (prep_en),
    .item_i    (item_q),
    .entry_i   (entry_rd),
    .cfg_i     (cfg),
    .entry_o   (entry_wr),
    .result_o  (res_new)
  );

  cbt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------- result register ----------------
  always_comb begin
    res_valid_d = res_valid_q;
    if (result_o.ready) begin
      res_valid_d = 1'b0;
    end
    if (commit) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      res_q <= res_new;
    end
  end

  assign result_o.valid            = res_valid_q;
  assign result_o.granted          = res_q.granted;
  assign result_o.grant_state      = res_q.grant_state;
  assign result_o.grant_generation = res_q.grant_generation;
  assign result_o.breaker_state    = res_q.breaker_state;
  assign result_o.tripped          = res_q.tripped;

`ifndef SYNTH
  // an accepted beat always starts the read-modify-write sequence
  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == FSM_PREP)
    else $error("accepted beat did not enter prep");

  // a new result appears only out of the write-back cycle
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q == FSM_COMMIT))
    else $error("result appeared outside write back");

  // a trip leaves the breaker open and grants nothing
  a_trip_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.tripped) |->
      (res_q.breaker_state == MODE_OPEN && !res_q.granted))
    else $error("trip without open state");

  // a grant reports the state the breaker is left in
  a_grant_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.granted) |-> (res_q.grant_state == res_q.breaker_state))
    else $error("grant state mismatch");
`endif

endmodule
